FILE: hw/rtl/bmd_pkg.sv
`timescale 1ns / 1ps
package bmd_pkg;

  localparam int MAX_OUT_ROWS_DEF = 1024;
  localparam int MAX_SIDE_DEF     = 16;
  localparam int PIXEL_BITS_DEF   = 16;

  localparam int SAMPLE_W     = 16;
  localparam int MEAN_W       = 16;
  localparam int CFG_W        = 11;
  localparam int CFG_IDX_W    = 2;
  localparam int SIDE_REG_W   = 5;
  localparam int SIDE_REG_MAX = (1 << SIDE_REG_W) - 1;
  localparam int WIDTH_MAX    = 1024;
  localparam int BCOL_W       = 10;
  localparam int QUEUE_DEPTH  = 4;
  localparam int QLVL_W       = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_OUT_WIDTH  = 2'd0,
    CFG_OUT_HEIGHT = 2'd1,
    CFG_SIDE       = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic [CFG_W-1:0]      out_width;
    logic [CFG_W-1:0]      out_height;
    logic [SIDE_REG_W-1:0] side;
  } cfg_regs_t;

  typedef enum logic {
    FR_RUN,
    FR_ALIGN
  } front_state_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIV,
    BK_DONE
  } back_state_t;

  function automatic int f_clamp(int v, int hi);
    if (v == 0) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic int f_smax(int max_side);
    return (max_side < SIDE_REG_MAX) ? max_side : SIDE_REG_MAX;
  endfunction

  function automatic int f_sw(int max_side);
    return $clog2(f_smax(max_side) + 1);
  endfunction

  function automatic int f_sq_w(int max_side);
    int sm;
    sm = f_smax(max_side);
    return $clog2(sm * sm + 1);
  endfunction

  function automatic int f_sum_w(int pixel_bits, int max_side);
    int sm;
    sm = f_smax(max_side);
    return pixel_bits + $clog2(sm * sm);
  endfunction

  function automatic int f_pos_w(int max_rows, int max_side);
    int w;
    w = $clog2(max_rows * f_smax(max_side) + 1);
    return (w < 2) ? 2 : w;
  endfunction

  function automatic int f_addr_w(int depth);
    return (depth > 1) ? $clog2(depth) : 1;
  endfunction

endpackage

FILE: hw/rtl/bmd_if.sv
`timescale 1ns / 1ps
interface bmd_in_if import bmd_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

interface bmd_out_if import bmd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [MEAN_W-1:0] mean;
  logic              frame_end;

  modport source (output valid, output mean, output frame_end, input ready);
  modport sink (input valid, input mean, input frame_end, output ready);
endinterface

FILE: hw/rtl/block_mean_downsampler.sv
`timescale 1ns / 1ps
// Pixels go through the accumulate stage into the queue; the back end registers each mean,
//   above side 1 after one divider step per sum bit (24 at default parameters).
// Throughput: one pixel per cycle while the shift-subtract divider keeps up and the queue
//   has room; each mean above side 1 holds the divider, and sides 2 to 4 pace the input.
// Reset (sync, rst_n low) clears counters, queue and output, sets registers to 1; row sums
//   are not cleared. A side write starts a realignment with input held.
module block_mean_downsampler import bmd_pkg::*; #(
  parameter int MAX_OUT_ROWS = MAX_OUT_ROWS_DEF,
  parameter int MAX_SIDE = MAX_SIDE_DEF,
  parameter int PIXEL_BITS = PIXEL_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [CFG_W-1:0]     cfg_data,
  bmd_in_if.sink               in_ch,
  bmd_out_if.source            out_ch
);

  localparam int SUM_W = f_sum_w(PIXEL_BITS, MAX_SIDE);

  cfg_regs_t         cfg_r;
  logic              side_wr;
  logic              q_push, q_pop, q_empty;
  logic [SUM_W:0]    q_push_data, q_pop_data;
  logic [QLVL_W-1:0] q_level;

  assign side_wr = cfg_we && (cfg_idx == CFG_SIDE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.out_width  <= CFG_W'(1);
      cfg_r.out_height <= CFG_W'(1);
      cfg_r.side       <= SIDE_REG_W'(1);
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_OUT_WIDTH: cfg_r.out_width <= cfg_data;
        CFG_OUT_HEIGHT: cfg_r.out_height <= cfg_data;
        CFG_SIDE: cfg_r.side <= cfg_data[SIDE_REG_W-1:0];
        default: ;
      endcase
    end
  end

  bmd_front #(
    .MAX_OUT_ROWS (MAX_OUT_ROWS),
    .MAX_SIDE     (MAX_SIDE),
    .PIXEL_BITS   (PIXEL_BITS)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .cfg         (cfg_r),
    .side_wr     (side_wr),
    .q_level     (q_level),
    .q_push      (q_push),
    .q_push_data (q_push_data)
  );

  bmd_queue #(
    .W     (SUM_W + 1),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_push_data),
    .pop       (q_pop),
    .pop_data  (q_pop_data),
    .empty     (q_empty),
    .level     (q_level)
  );

  bmd_back #(
    .MAX_SIDE   (MAX_SIDE),
    .PIXEL_BITS (PIXEL_BITS)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .q_empty (q_empty),
    .q_data  (q_pop_data),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule

FILE: hw/rtl/bmd_ram.sv
`timescale 1ns / 1ps
module bmd_ram import bmd_pkg::*; #(
  parameter int W = 8,
  parameter int DEPTH = 16,
  localparam int AW = f_addr_w(DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);

  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hw/rtl/bmd_queue.sv
`timescale 1ns / 1ps
module bmd_queue import bmd_pkg::*; #(
  parameter int W = 8,
  parameter int DEPTH = QUEUE_DEPTH,
  localparam int PW = f_addr_w(DEPTH),
  localparam int LW = $clog2(DEPTH + 1)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  logic [W-1:0]  push_data,
  input  logic          pop,
  output logic [W-1:0]  pop_data,
  output logic          empty,
  output logic [LW-1:0] level
);

  logic [W-1:0]  ent_r [DEPTH];
  logic [PW-1:0] wp_r, rp_r;
  logic [LW-1:0] lvl_r;

  assign pop_data = ent_r[rp_r];
  assign empty    = (lvl_r == '0);
  assign level    = lvl_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      lvl_r <= '0;
    end else begin
      if (push) begin
        wp_r <= (wp_r == PW'(DEPTH - 1)) ? '0 : wp_r + PW'(1);
      end
      if (pop) begin
        rp_r <= (rp_r == PW'(DEPTH - 1)) ? '0 : rp_r + PW'(1);
      end
      if (push && !pop) begin
        lvl_r <= lvl_r + LW'(1);
      end else if (pop && !push) begin
        lvl_r <= lvl_r - LW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wp_r] <= push_data;
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |-> (lvl_r < LW'(DEPTH)))
    else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !empty)
    else $error("queue underflow");
`endif

endmodule

FILE: hw/rtl/bmd_front.sv
`timescale 1ns / 1ps
module bmd_front import bmd_pkg::*; #(
  parameter int MAX_OUT_ROWS = MAX_OUT_ROWS_DEF,
  parameter int MAX_SIDE = MAX_SIDE_DEF,
  parameter int PIXEL_BITS = PIXEL_BITS_DEF,
  localparam int SUM_W = f_sum_w(PIXEL_BITS, MAX_SIDE)
) (
  input  logic              clk,
  input  logic              rst_n,
  bmd_in_if.sink            in_ch,
  input  cfg_regs_t         cfg,
  input  logic              side_wr,
  input  logic [QLVL_W-1:0] q_level,
  output logic              q_push,
  output logic [SUM_W:0]    q_push_data
);

  localparam int S_MAX  = f_smax(MAX_SIDE);
  localparam int SW     = f_sw(MAX_SIDE);
  localparam int POS_W  = f_pos_w(MAX_OUT_ROWS, MAX_SIDE);
  localparam int AW     = f_addr_w(MAX_OUT_ROWS);
  localparam int ACNT_W = $clog2(POS_W + 1);
  localparam int PX_EXT = (PIXEL_BITS > SAMPLE_W) ? PIXEL_BITS : SAMPLE_W;

  front_state_t fst_r, fst_nxt;

  logic [POS_W-1:0]  pos_r, row_r;
  logic [SW-1:0]     r_r, cib_r;
  logic [BCOL_W-1:0] bcol_r;
  logic [ACNT_W-1:0] acnt_r;

  logic [SW-1:0]     s_eff;
  logic [POS_W-1:0]  h_eff;
  logic [CFG_W-1:0]  w_eff;

  logic              col_wrap;
  logic [POS_W-1:0]  pe, rowe;
  logic [SW-1:0]     re, ce;
  logic [BCOL_W-1:0] be;
  logic              seg_end, row_last, col_end, cib_last, blk_end, bcol_last;
  logic              first_e, last_e, fend_e;
  logic [AW-1:0]     addr_e;
  logic [PIXEL_BITS-1:0] pix;

  logic [POS_W-1:0]  pos_nxt, row_nxt;
  logic [SW-1:0]     r_nxt, cib_nxt;
  logic [BCOL_W-1:0] bcol_nxt;

  logic [SW:0]       rem_sh;
  logic              ge;
  logic [SW-1:0]     arem_nxt;
  logic [POS_W-1:0]  aquo_nxt;

  logic              in_rdy, align_step, room, accept;

  logic                  s1_v_r, s1_first_r, s1_last_r, s1_fend_r;
  logic [PIXEL_BITS-1:0] s1_pix_r;
  logic [AW-1:0]         s1_addr_r;
  logic                  pv_v_r;
  logic [AW-1:0]         pv_addr_r;
  logic [SUM_W-1:0]      pv_sum_r;
  logic [SUM_W-1:0]      rdata, base, s1_sum;

  assign s_eff = SW'(f_clamp(int'(cfg.side), S_MAX));
  assign h_eff = POS_W'(f_clamp(int'(cfg.out_height), MAX_OUT_ROWS));
  assign w_eff = CFG_W'(f_clamp(int'(cfg.out_width), WIDTH_MAX));

  // counters restart when a register change has put them out of bounds
  assign col_wrap = (row_r >= h_eff);
  assign pe   = col_wrap ? '0 : pos_r;
  assign rowe = col_wrap ? '0 : row_r;
  assign re   = col_wrap ? '0 : r_r;
  assign ce   = (cib_r >= s_eff) ? '0 : cib_r;
  assign be   = ({1'b0, bcol_r} >= w_eff) ? '0 : bcol_r;

  assign seg_end   = (re == s_eff - SW'(1));
  assign row_last  = (rowe == h_eff - POS_W'(1));
  assign cib_last  = (ce == s_eff - SW'(1));
  assign bcol_last = ({1'b0, be} == w_eff - CFG_W'(1));
  assign col_end   = seg_end && row_last;
  assign blk_end   = col_end && cib_last;

  assign first_e = (re == '0) && (ce == '0);
  assign last_e  = seg_end && cib_last;
  assign fend_e  = row_last && bcol_last;
  assign addr_e  = rowe[AW-1:0];
  assign pix     = PIXEL_BITS'(PX_EXT'(in_ch.sample));

  assign pos_nxt  = col_end ? '0 : pe + POS_W'(1);
  assign r_nxt    = seg_end ? '0 : re + SW'(1);
  assign row_nxt  = col_end ? '0 : (seg_end ? rowe + POS_W'(1) : rowe);
  assign cib_nxt  = col_end ? (cib_last ? '0 : ce + SW'(1)) : ce;
  assign bcol_nxt = blk_end ? (bcol_last ? '0 : be + BCOL_W'(1)) : be;

  // realignment after a side change: row_r / r_r = pos_r / s, one bit a cycle
  assign rem_sh   = {r_r, row_r[POS_W-1]};
  assign ge       = (rem_sh >= {1'b0, s_eff});
  assign arem_nxt = ge ? SW'(rem_sh - {1'b0, s_eff}) : SW'(rem_sh);
  assign aquo_nxt = (row_r << 1) | POS_W'(ge);

  assign room   = (int'(q_level) + int'(s1_v_r)) < QUEUE_DEPTH;
  assign accept = in_ch.valid && in_rdy;
  assign in_ch.ready = in_rdy;

  always_comb begin
    fst_nxt = fst_r;
    case (fst_r)
      FR_RUN: begin
        if (side_wr) fst_nxt = FR_ALIGN;
      end
      FR_ALIGN: begin
        if (!side_wr && acnt_r == ACNT_W'(POS_W - 1)) fst_nxt = FR_RUN;
      end
      default: fst_nxt = FR_RUN;
    endcase
  end

  always_comb begin
    in_rdy     = 1'b0;
    align_step = 1'b0;
    case (fst_r)
      FR_RUN: in_rdy = !side_wr && room;
      FR_ALIGN: align_step = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fst_r  <= FR_RUN;
      pos_r  <= '0;
      row_r  <= '0;
      r_r    <= '0;
      cib_r  <= '0;
      bcol_r <= '0;
      acnt_r <= '0;
      s1_v_r <= 1'b0;
      pv_v_r <= 1'b0;
    end else begin
      fst_r  <= fst_nxt;
      s1_v_r <= accept;
      pv_v_r <= s1_v_r;
      if (side_wr) begin
        row_r  <= pos_r;
        r_r    <= '0;
        acnt_r <= '0;
      end else if (align_step) begin
        row_r  <= aquo_nxt;
        r_r    <= arem_nxt;
        acnt_r <= acnt_r + ACNT_W'(1);
      end else if (accept) begin
        pos_r  <= pos_nxt;
        row_r  <= row_nxt;
        r_r    <= r_nxt;
        cib_r  <= cib_nxt;
        bcol_r <= bcol_nxt;
      end
    end
  end

  // accumulate stage; the entry written last cycle is not yet visible in rdata
  assign base   = (pv_v_r && pv_addr_r == s1_addr_r) ? pv_sum_r : rdata;
  assign s1_sum = s1_first_r ? SUM_W'(s1_pix_r) : base + SUM_W'(s1_pix_r);

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pix_r   <= pix;
      s1_addr_r  <= addr_e;
      s1_first_r <= first_e;
      s1_last_r  <= last_e;
      s1_fend_r  <= fend_e;
    end
    pv_addr_r <= s1_addr_r;
    pv_sum_r  <= s1_sum;
  end

  bmd_ram #(
    .W     (SUM_W),
    .DEPTH (MAX_OUT_ROWS)
  ) u_row_sums (
    .clk   (clk),
    .we    (s1_v_r),
    .waddr (s1_addr_r),
    .wdata (s1_sum),
    .raddr (addr_e),
    .rdata (rdata)
  );

  assign q_push      = s1_v_r && s1_last_r;
  assign q_push_data = {s1_fend_r, s1_sum};

`ifndef NO_ASSERTIONS
  a_align_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (fst_r == FR_ALIGN) |-> !(in_ch.valid && in_ch.ready))
    else $error("transfer during realignment");
  a_rem_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (fst_r == FR_RUN) |-> (r_r < s_eff))
    else $error("row offset not below side");
`endif

endmodule

FILE: hw/rtl/bmd_back.sv
`timescale 1ns / 1ps
module bmd_back import bmd_pkg::*; #(
  parameter int MAX_SIDE = MAX_SIDE_DEF,
  parameter int PIXEL_BITS = PIXEL_BITS_DEF,
  localparam int SUM_W = f_sum_w(PIXEL_BITS, MAX_SIDE)
) (
  input  logic           clk,
  input  logic           rst_n,
  input  cfg_regs_t      cfg,
  input  logic           q_empty,
  input  logic [SUM_W:0] q_data,
  output logic           q_pop,
  bmd_out_if.source      out_ch
);

  localparam int S_MAX = f_smax(MAX_SIDE);
  localparam int SW    = f_sw(MAX_SIDE);
  localparam int SQ_W  = f_sq_w(MAX_SIDE);
  localparam int CW    = $clog2(SUM_W + 1);

  back_state_t bst_r, bst_nxt;

  logic [SW-1:0]     s_eff;
  logic              one;
  logic [SUM_W-1:0]  quo_r, quo_nxt;
  logic [SQ_W-1:0]   rem_r, rem_nxt, sq_r;
  logic [SQ_W:0]     rem_sh;
  logic              ge;
  logic [CW-1:0]     cnt_r;
  logic              fend_r;
  logic              out_v_r, out_fend_r;
  logic [MEAN_W-1:0] out_mean_r;
  logic              slot_free, take, div_step, ld_out;

  assign s_eff = SW'(f_clamp(int'(cfg.side), S_MAX));
  assign one   = (s_eff == SW'(1));

  assign rem_sh  = {rem_r, quo_r[SUM_W-1]};
  assign ge      = (rem_sh >= {1'b0, sq_r});
  assign rem_nxt = ge ? SQ_W'(rem_sh - {1'b0, sq_r}) : SQ_W'(rem_sh);
  assign quo_nxt = (quo_r << 1) | SUM_W'(ge);

  assign slot_free = !out_v_r || out_ch.ready;
  assign q_pop     = take && !q_empty;

  always_comb begin
    take     = 1'b0;
    div_step = 1'b0;
    ld_out   = 1'b0;
    case (bst_r)
      BK_IDLE: take = 1'b1;
      BK_DIV: div_step = 1'b1;
      BK_DONE: begin
        ld_out = slot_free;
        take   = slot_free;
      end
      default: ;
    endcase
  end

  always_comb begin
    bst_nxt = bst_r;
    case (bst_r)
      BK_IDLE: begin
        if (q_pop) bst_nxt = one ? BK_DONE : BK_DIV;
      end
      BK_DIV: begin
        if (cnt_r == CW'(SUM_W - 1)) bst_nxt = BK_DONE;
      end
      BK_DONE: begin
        if (slot_free) bst_nxt = q_pop ? (one ? BK_DONE : BK_DIV) : BK_IDLE;
      end
      default: bst_nxt = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bst_r   <= BK_IDLE;
      cnt_r   <= '0;
      out_v_r <= 1'b0;
    end else begin
      bst_r <= bst_nxt;
      if (q_pop) begin
        cnt_r <= '0;
      end else if (div_step) begin
        cnt_r <= cnt_r + CW'(1);
      end
      if (ld_out) begin
        out_v_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      quo_r  <= q_data[SUM_W-1:0];
      fend_r <= q_data[SUM_W];
      rem_r  <= '0;
      sq_r   <= SQ_W'(int'(s_eff) * int'(s_eff));
    end else if (div_step) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
    if (ld_out) begin
      out_mean_r <= MEAN_W'(quo_r);
      out_fend_r <= fend_r;
    end
  end

  assign out_ch.valid     = out_v_r;
  assign out_ch.mean      = out_mean_r;
  assign out_ch.frame_end = out_fend_r;

`ifndef NO_ASSERTIONS
  a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
    (bst_r == BK_DIV) |-> (rem_r < sq_r))
    else $error("divider remainder out of range");
`endif

endmodule
